// ===== design/pwkd_pkg.sv =====
// Shared types and constants of the pulse width key decoder.
package pwkd_pkg;

   localparam int DUR_W       = 20;
   localparam int KEY_W       = 64;
   localparam int LEN_W       = 7;
   localparam int COUNT_W     = 8;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 72;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register index, taken from paddr[4:2].
   typedef enum logic [2:0] {
      CSR_SHORT_TIME    = 3'd0,
      CSR_LONG_TIME     = 3'd1,
      CSR_TOLERANCE     = 3'd2,
      CSR_GAP_TIME      = 3'd3,
      CSR_GAP_TOLERANCE = 3'd4,
      CSR_KEY_BITS      = 3'd5
   } csr_index_type;

   localparam logic [DUR_W-1:0] SHORT_TIME_RST    = 20'd230;
   localparam logic [DUR_W-1:0] LONG_TIME_RST     = 20'd1550;
   localparam logic [DUR_W-1:0] TOLERANCE_RST     = 20'd160;
   localparam logic [DUR_W-1:0] GAP_TIME_RST      = 20'd12400;
   localparam logic [DUR_W-1:0] GAP_TOLERANCE_RST = 20'd2080;
   localparam logic [LEN_W-1:0] KEY_BITS_RST      = 7'd18;

   typedef struct packed {
      logic [DUR_W-1:0] short_time;
      logic [DUR_W-1:0] long_time;
      logic [DUR_W-1:0] tolerance;
      logic [DUR_W-1:0] gap_time;
      logic [DUR_W-1:0] gap_tolerance;
      logic [LEN_W-1:0] key_bits;
   } cfg_type;

   typedef struct packed {
      logic             level;
      logic [DUR_W-1:0] duration_us;
   } item_type;

   typedef struct packed {
      logic             emit;
      logic [KEY_W-1:0] key_value;
      logic [LEN_W-1:0] key_length;
   } result_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'b001,
      PH_WANT_HIGH = 3'b010,
      PH_WANT_LOW  = 3'b100
   } phase_type;

endpackage

// ===== design/pwkd_csr.sv =====
// Configuration register file with its APB-style access port.
module pwkd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pwkd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pwkd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pwkd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output pwkd_pkg::cfg_type                 cfg
);
   import pwkd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_SHORT_TIME:    cfg_in.short_time    = csr_pwdata[DUR_W-1:0];
            CSR_LONG_TIME:     cfg_in.long_time     = csr_pwdata[DUR_W-1:0];
            CSR_TOLERANCE:     cfg_in.tolerance     = csr_pwdata[DUR_W-1:0];
            CSR_GAP_TIME:      cfg_in.gap_time      = csr_pwdata[DUR_W-1:0];
            CSR_GAP_TOLERANCE: cfg_in.gap_tolerance = csr_pwdata[DUR_W-1:0];
            CSR_KEY_BITS:      cfg_in.key_bits      = csr_pwdata[LEN_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_SHORT_TIME:    csr_prdata = CSR_DATA_W'(cfg_ff.short_time);
         CSR_LONG_TIME:     csr_prdata = CSR_DATA_W'(cfg_ff.long_time);
         CSR_TOLERANCE:     csr_prdata = CSR_DATA_W'(cfg_ff.tolerance);
         CSR_GAP_TIME:      csr_prdata = CSR_DATA_W'(cfg_ff.gap_time);
         CSR_GAP_TOLERANCE: csr_prdata = CSR_DATA_W'(cfg_ff.gap_tolerance);
         CSR_KEY_BITS:      csr_prdata = CSR_DATA_W'(cfg_ff.key_bits);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_time    <= SHORT_TIME_RST;
         cfg_ff.long_time     <= LONG_TIME_RST;
         cfg_ff.tolerance     <= TOLERANCE_RST;
         cfg_ff.gap_time      <= GAP_TIME_RST;
         cfg_ff.gap_tolerance <= GAP_TOLERANCE_RST;
         cfg_ff.key_bits      <= KEY_BITS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/pwkd_core.sv =====
// Decoder state machine, bit store and key match for one segment per cycle while step is high.
module pwkd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  pwkd_pkg::cfg_type    cfg,
   input  pwkd_pkg::item_type   item,
   input  logic                 step,
   output pwkd_pkg::result_type result
);
   import pwkd_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [DUR_W-1:0]   saved_ff, saved_in;
   logic [KEY_W-1:0]   store_ff, store_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               h_long, h_short, d_short, d_long, d_gap;
   logic [KEY_W-1:0]   gap_store;
   logic [COUNT_W-1:0] gap_count;

   // Strict absolute-tolerance match.
   function automatic logic near(input logic [DUR_W-1:0] x,
                                 input logic [DUR_W-1:0] t,
                                 input logic [DUR_W-1:0] tol);
      logic [DUR_W-1:0] d;
      d = (x > t) ? (x - t) : (t - x);
      return d < tol;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

   assign h_long  = near(saved_ff, cfg.long_time, cfg.tolerance);
   assign h_short = near(saved_ff, cfg.short_time, cfg.tolerance);
   assign d_short = near(item.duration_us, cfg.short_time, cfg.tolerance);
   assign d_long  = near(item.duration_us, cfg.long_time, cfg.tolerance);
   assign d_gap   = near(item.duration_us, cfg.gap_time, cfg.gap_tolerance);

   // A gap closes the frame with a 1 for a long high, then a 0 for a short one.
   always_comb begin
      gap_store = store_ff;
      gap_count = count_ff;
      if (h_long) begin
         gap_store = {gap_store[KEY_W-2:0], 1'b1};
         gap_count = sat_inc(gap_count);
      end
      if (h_short) begin
         gap_store = {gap_store[KEY_W-2:0], 1'b0};
         gap_count = sat_inc(gap_count);
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      saved_in          = saved_ff;
      store_in          = store_ff;
      count_in          = count_ff;
      result.emit       = 1'b0;
      result.key_value  = gap_store;
      result.key_length = gap_count[LEN_W-1:0];
      unique case (phase_ff)
         PH_WANT_HIGH: begin
            if (item.level) begin
               saved_in = item.duration_us;
               phase_in = PH_WANT_LOW;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_WANT_LOW: begin
            if (item.level) begin
               phase_in = PH_IDLE;
            end else if (h_long && d_short) begin
               store_in = {store_ff[KEY_W-2:0], 1'b1};
               count_in = sat_inc(count_ff);
               phase_in = PH_WANT_HIGH;
            end else if (h_short && d_long) begin
               store_in = {store_ff[KEY_W-2:0], 1'b0};
               count_in = sat_inc(count_ff);
               phase_in = PH_WANT_HIGH;
            end else if (d_gap) begin
               result.emit = (gap_count == COUNT_W'(cfg.key_bits));
               store_in    = '0;
               count_in    = '0;
               phase_in    = PH_IDLE;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            if (!item.level && d_gap) begin
               store_in = '0;
               count_in = '0;
               phase_in = PH_WANT_HIGH;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         saved_ff <= '0;
         store_ff <= '0;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         saved_ff <= saved_in;
         store_ff <= store_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/pulse_width_key_decoder_top.sv =====
// Top level of the pulse width key decoder: input and result registers around the core.
//
// Usage. Each transfer on the req_ channel carries one radio level segment:
// req_tuser is the level (1 high, 0 low) and req_tdata[19:0] its duration in
// microseconds. After a low gap that matches gap_time the decoder collects
// pulse pairs into a bit store; on the closing gap a key of exactly key_bits
// bits is delivered as one transfer on the rsp_ channel, with the key value in
// rsp_tdata[63:0] (first bit received most significant) and its length in
// rsp_tdata[70:64]. Segments that yield no key produce no transfer at all.
// The segment waits in the input register, the decode logic loads the result
// register from it, and the key is on rsp_ once that register holds it.
// Throughput is one segment per cycle while the receiver keeps up, set by the
// decode step between the two registers. When the receiver stalls, a pending
// key waits in the result register; segments that produce no key keep
// flowing, and one further segment may wait in the input register before
// req_tready drops. Reset returns the decoder to waiting for a gap, empties
// both registers, clears the bit store and restores all configuration
// registers to their defaults. Configuration must be written through the
// csr_ port only while idle; the block itself does not enforce this.
module pulse_width_key_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   // Input segments.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pwkd_pkg::REQ_DATA_W-1:0]   req_tdata,   // [19:0] duration_us, rest zero
   input  logic                              req_tuser,   // [0] level
   // Decoded keys.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pwkd_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [63:0] key_value, [70:64] key_length
   // Configuration.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pwkd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pwkd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pwkd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import pwkd_pkg::*;

   cfg_type    cfg;
   result_type result;

   // Input register: one segment waiting for the decode step.
   logic       in_vld_ff, in_vld_in;
   item_type   in_item_ff;

   // Result register: one key waiting for the receiver.
   logic       out_vld_ff, out_vld_in;
   logic [KEY_W-1:0] out_key_ff;
   logic [LEN_W-1:0] out_len_ff;

   logic       accept;
   logic       advance;
   logic       load_out;

   // A held segment moves on unless it would produce a key while the
   // result register is still full and not being drained.
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready || !result.emit);
   assign load_out   = advance && result.emit;
   assign req_tready = !in_vld_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (load_out) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.level       <= req_tuser;
         in_item_ff.duration_us <= req_tdata[DUR_W-1:0];
      end
      if (load_out) begin
         out_key_ff <= result.key_value;
         out_len_ff <= result.key_length;
      end
   end

   pwkd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pwkd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (in_item_ff),
      .step   (advance),
      .result (result)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_len_ff, out_key_ff};

endmodule

// ===== test/pulse_width_key_decoder_top_tb.sv =====
// Self-checking testbench for the pulse width key decoder top level.
`timescale 1ns / 100ps

module pulse_width_key_decoder_top_tb;
   import pwkd_pkg::*;

   // One decoded key as it travels on the result channel.
   typedef struct packed {
      logic [KEY_W-1:0] value;
      logic [LEN_W-1:0] length;
   } key_type;

   // How a row of the directed table is checked: by the decoder model, or
   // against a key (or the absence of one) typed into the table.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NO_KEY,
      ROW_KEY
   } row_kind_type;

   typedef struct packed {
      logic             lvl;
      logic [DUR_W-1:0] dur;
      row_kind_type     kind;
      key_type          key;
   } seg_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [19:0] duration_us, rest zero
   logic                  req_tuser;   // [0] level
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [63:0] key_value, [70:64] key_length, rest zero
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pulse_width_key_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // A 12 ns clock. Inputs change on the falling edge and outputs are looked
   // at on the rising edge, so nothing depends on event order within a step.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow of the configuration registers, as the decoder should see them.
   cfg_type        cfg_shadow;

   // Decoder state as it should be after every accepted segment.
   phase_type        dec_phase;
   logic [DUR_W-1:0] dec_saved;
   logic [KEY_W-1:0] dec_store;
   logic [COUNT_W-1:0] dec_count;

   // Keys that the decoder owes us, oldest first.
   key_type pending_keys [$];

   int  mismatch_count = 0;
   int  segments_sent  = 0;
   bit  steady         = 1'b0;   // no idle cycles on either side while set
   bit  sink_hold_off  = 1'b0;   // asks the key sink for one long stall

   // Directed table, written for the reset timings with key_bits set to 2.
   // Only the two keys and the empty closing gap are typed in; the rest is
   // left to the decoder model.
   seg_row_type directed_rows [28] = '{
      '{1'b1, 20'd1048575, ROW_PREDICT, '0},        // high while idle is ignored
      '{1'b0, 20'd0,       ROW_PREDICT, '0},        // zero-length low is no gap
      '{1'b0, 20'd10320,   ROW_PREDICT, '0},        // just outside the gap window
      '{1'b0, 20'd10321,   ROW_PREDICT, '0},        // just inside the gap window
      '{1'b0, 20'd230,     ROW_PREDICT, '0},        // low while a high is due
      '{1'b0, 20'd14479,   ROW_PREDICT, '0},        // upper edge of the gap window
      '{1'b1, 20'd1550,    ROW_PREDICT, '0},
      '{1'b0, 20'd230,     ROW_PREDICT, '0},        // long then short: a one
      '{1'b1, 20'd230,     ROW_PREDICT, '0},
      '{1'b0, 20'd12400,   ROW_KEY,     '{64'd2, 7'd2}},  // gap appends a zero
      '{1'b0, 20'd12400,   ROW_PREDICT, '0},
      '{1'b1, 20'd1709,    ROW_PREDICT, '0},        // long, at the top edge
      '{1'b0, 20'd71,      ROW_PREDICT, '0},        // short, at the bottom edge
      '{1'b1, 20'd1550,    ROW_PREDICT, '0},
      '{1'b1, 20'd230,     ROW_PREDICT, '0},        // high while a low is due
      '{1'b0, 20'd12400,   ROW_PREDICT, '0},
      '{1'b1, 20'd1390,    ROW_PREDICT, '0},        // neither short nor long
      '{1'b0, 20'd12400,   ROW_NO_KEY,  '0},        // gap appends nothing
      '{1'b0, 20'd12400,   ROW_PREDICT, '0},
      '{1'b1, 20'd230,     ROW_PREDICT, '0},
      '{1'b0, 20'd1550,    ROW_PREDICT, '0},        // short then long: a zero
      '{1'b1, 20'd1550,    ROW_PREDICT, '0},
      '{1'b0, 20'd1550,    ROW_PREDICT, '0},        // low that fits nothing
      '{1'b0, 20'd12400,   ROW_PREDICT, '0},
      '{1'b1, 20'd230,     ROW_PREDICT, '0},
      '{1'b0, 20'd1550,    ROW_PREDICT, '0},
      '{1'b1, 20'd1550,    ROW_PREDICT, '0},
      '{1'b0, 20'd12400,   ROW_KEY,     '{64'd1, 7'd2}}   // gap appends a one
   };

   // ------------------------------------------------------------------
   // Decoder model.
   // ------------------------------------------------------------------

   // True when x lies strictly within tol of t.
   function automatic bit near_match(input logic [DUR_W-1:0] x, input logic [DUR_W-1:0] t,
                                     input logic [DUR_W-1:0] tol);
      logic [DUR_W-1:0] d;
      d = (x > t) ? x - t : t - x;
      return d < tol;
   endfunction

   task automatic shift_in(input bit b);
      dec_store = {dec_store[KEY_W-2:0], b};
      if (dec_count != COUNT_MAX) dec_count++;
   endtask

   // Advances the model by one segment and says whether a key comes out.
   task automatic decode_segment(input bit lvl, input logic [DUR_W-1:0] dur,
                                 output bit emit, output key_type key);
      bit h_long;
      bit h_short;
      emit    = 1'b0;
      key     = '0;
      h_long  = near_match(dec_saved, cfg_shadow.long_time, cfg_shadow.tolerance);
      h_short = near_match(dec_saved, cfg_shadow.short_time, cfg_shadow.tolerance);
      case (dec_phase)
         PH_WANT_HIGH: begin
            if (lvl) begin
               dec_saved = dur;
               dec_phase = PH_WANT_LOW;
            end else begin
               dec_phase = PH_IDLE;
            end
         end
         PH_WANT_LOW: begin
            if (lvl) begin
               dec_phase = PH_IDLE;
            end else if (h_long &&
                         near_match(dur, cfg_shadow.short_time, cfg_shadow.tolerance)) begin
               shift_in(1'b1);
               dec_phase = PH_WANT_HIGH;
            end else if (h_short &&
                         near_match(dur, cfg_shadow.long_time, cfg_shadow.tolerance)) begin
               shift_in(1'b0);
               dec_phase = PH_WANT_HIGH;
            end else if (near_match(dur, cfg_shadow.gap_time, cfg_shadow.gap_tolerance)) begin
               // A closing gap: a high that fits both timings gives a one and
               // then a zero, one that fits neither gives nothing.
               if (h_long) shift_in(1'b1);
               if (h_short) shift_in(1'b0);
               if (dec_count == {1'b0, cfg_shadow.key_bits}) begin
                  emit       = 1'b1;
                  key.value  = dec_store;
                  key.length = dec_count[LEN_W-1:0];
               end
               dec_store = '0;
               dec_count = '0;
               dec_phase = PH_IDLE;
            end else begin
               dec_phase = PH_IDLE;
            end
         end
         default: begin
            if (!lvl && near_match(dur, cfg_shadow.gap_time, cfg_shadow.gap_tolerance)) begin
               dec_store = '0;
               dec_count = '0;
               dec_phase = PH_WANT_HIGH;
            end else begin
               dec_phase = PH_IDLE;
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Failure bookkeeping.
   // ------------------------------------------------------------------

   task automatic note_mismatch(input string what, input logic [71:0] want,
                                input logic [71:0] got);
      if (mismatch_count < 10)
         $display("mismatch: %s: expected %h, got %h", what, want, got);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Random helpers.
   // ------------------------------------------------------------------

   // Idle cycles before a transfer: mostly none, sometimes a few, now and
   // then a long pause.
   function automatic int idle_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // A duration near t. Clean ones lie strictly within a nonzero tol, edges included
   // now and then; dirty ones may fall on or past the edge, or anywhere.
   function automatic logic [DUR_W-1:0] dur_near(input logic [DUR_W-1:0] t,
                                                 input logic [DUR_W-1:0] tol,
                                                 input bit clean);
      int v;
      int c;
      int w;
      int r;
      c = int'(t);
      w = int'(tol);
      r = $urandom_range(0, 99);
      if (!clean && r < 20) begin
         if (r < 8) v = c + w;
         else if (r < 16) v = c - w;
         else v = $urandom_range(0, 1048575);
      end else if (w == 0) begin
         v = c;
      end else if (r >= 90) begin
         v = (r >= 95) ? c + w - 1 : c - w + 1;
      end else begin
         v = c - (w - 1) + $urandom_range(0, 2 * (w - 1));
      end
      if (v < 0) v = 0;
      if (v > 1048575) v = 1048575;
      return v[DUR_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Configuration port.
   // ------------------------------------------------------------------

   function automatic logic [CSR_DATA_W-1:0] shadow_value(input csr_index_type idx);
      case (idx)
         CSR_SHORT_TIME:    return CSR_DATA_W'(cfg_shadow.short_time);
         CSR_LONG_TIME:     return CSR_DATA_W'(cfg_shadow.long_time);
         CSR_TOLERANCE:     return CSR_DATA_W'(cfg_shadow.tolerance);
         CSR_GAP_TIME:      return CSR_DATA_W'(cfg_shadow.gap_time);
         CSR_GAP_TOLERANCE: return CSR_DATA_W'(cfg_shadow.gap_tolerance);
         default:           return CSR_DATA_W'(cfg_shadow.key_bits);
      endcase
   endfunction

   // A setup phase and then an access phase, entered and left on a falling edge.
   task automatic csr_access(input bit wr, input csr_index_type idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = wr;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic check_register(input csr_index_type idx);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, idx, '0, rd);
      if (rd !== shadow_value(idx))
         note_mismatch($sformatf("register %s read back", idx.name()),
                       72'(shadow_value(idx)), 72'(rd));
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, idx, val, rd);
      case (idx)
         CSR_SHORT_TIME:    cfg_shadow.short_time    = val[DUR_W-1:0];
         CSR_LONG_TIME:     cfg_shadow.long_time     = val[DUR_W-1:0];
         CSR_TOLERANCE:     cfg_shadow.tolerance     = val[DUR_W-1:0];
         CSR_GAP_TIME:      cfg_shadow.gap_time      = val[DUR_W-1:0];
         CSR_GAP_TOLERANCE: cfg_shadow.gap_tolerance = val[DUR_W-1:0];
         default:           cfg_shadow.key_bits      = val[LEN_W-1:0];
      endcase
      check_register(idx);
   endtask

   // ------------------------------------------------------------------
   // Segment source.
   // ------------------------------------------------------------------

   // Offers one segment, waits for its transfer and books the key it should
   // produce. Entered and left on a falling edge.
   task automatic send_segment(input bit lvl, input logic [DUR_W-1:0] dur,
                               input row_kind_type how = ROW_PREDICT,
                               input key_type typed_key = '0);
      int      gap;
      bit      emit;
      key_type key;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = lvl;
      req_tdata  = {{(REQ_DATA_W-DUR_W){1'b0}}, dur};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_segment(lvl, dur, emit, key);
      segments_sent++;
      case (how)
         ROW_KEY:    pending_keys.push_back(typed_key);
         ROW_NO_KEY: ;
         default:    if (emit) pending_keys.push_back(key);
      endcase
      @(negedge clock);
   endtask

   // A frame: an opening gap, then pairs of high and low. When closed, the
   // last pair ends in a gap instead of its low. Dirty frames carry timings
   // that may miss their window.
   task automatic send_frame(input int pairs, input bit closed, input bit clean);
      bit b;
      send_segment(1'b0, dur_near(cfg_shadow.gap_time, cfg_shadow.gap_tolerance, clean));
      for (int i = 0; i < pairs; i++) begin
         b = 1'($urandom_range(0, 1));
         send_segment(1'b1, dur_near(b ? cfg_shadow.long_time : cfg_shadow.short_time,
                                     cfg_shadow.tolerance, clean));
         if (closed && i == pairs - 1)
            send_segment(1'b0, dur_near(cfg_shadow.gap_time, cfg_shadow.gap_tolerance, clean));
         else
            send_segment(1'b0, dur_near(b ? cfg_shadow.short_time : cfg_shadow.long_time,
                                        cfg_shadow.tolerance, clean));
      end
   endtask

   // Loose segments of either level, some near a nominal timing and some
   // anywhere in the 20-bit range.
   task automatic send_noise(input int count);
      logic [DUR_W-1:0] d;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: d = dur_near(cfg_shadow.short_time, cfg_shadow.tolerance, 1'b0);
            1: d = dur_near(cfg_shadow.long_time, cfg_shadow.tolerance, 1'b0);
            2: d = dur_near(cfg_shadow.gap_time, cfg_shadow.gap_tolerance, 1'b0);
            default: d = DUR_W'($urandom_range(0, 1048575));
         endcase
         send_segment(1'($urandom_range(0, 1)), d);
      end
   endtask

   // Most frames are as long as key_bits so that keys come out; the rest
   // are of any length from 1 to key_bits + 3.
   function automatic int frame_length();
      int kb;
      kb = int'(cfg_shadow.key_bits);
      if (kb == 0) return 1;
      if ($urandom_range(0, 99) < 65) return kb;
      return $urandom_range(1, kb + 3);
   endfunction

   task automatic run_random(input int budget);
      int stop_at;
      int r;
      stop_at = segments_sent + budget;
      while (segments_sent < stop_at) begin
         steady = ($urandom_range(0, 7) == 0);
         r = $urandom_range(0, 99);
         if (r < 70) send_frame(frame_length(), $urandom_range(0, 9) != 0, 1'b1);
         else if (r < 85) send_frame(frame_length(), 1'b1, 1'b0);
         else send_noise($urandom_range(1, 6));
      end
      steady = 1'b0;
   endtask

   // Stops offering segments until every booked key has been seen, then
   // allows for a last segment still in the two pipeline registers.
   task automatic wait_for_keys();
      req_tvalid = 1'b0;
      while (pending_keys.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_config(input int s, input int l, input int tol, input int g,
                             input int gtol, input int kb);
      wait_for_keys();
      write_register(CSR_SHORT_TIME, s);
      write_register(CSR_LONG_TIME, l);
      write_register(CSR_TOLERANCE, tol);
      write_register(CSR_GAP_TIME, g);
      write_register(CSR_GAP_TOLERANCE, gtol);
      write_register(CSR_KEY_BITS, kb);
   endtask

   // ------------------------------------------------------------------
   // Key sink: stalls at random, and once for a long stretch on request.
   // ------------------------------------------------------------------
   initial begin : key_sink
      int stall;
      int hold;
      stall      = 0;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else if (sink_hold_off) begin
            // The long hold-off is counted here, cycle by cycle, while the
            // source keeps offering segments.
            hold          = 399;
            sink_hold_off = 1'b0;
            rsp_tready    = 1'b0;
         end else if (stall > 0) begin
            rsp_tready = 1'b0;
            stall--;
         end else begin
            rsp_tready = 1'b1;
            stall      = idle_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // Key checker: every key transfer is matched against the oldest booked
   // key, field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : key_checker
      key_type want;
      key_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value  = rsp_tdata[KEY_W-1:0];
         got.length = rsp_tdata[KEY_W +: LEN_W];
         if (pending_keys.size() == 0) begin
            note_mismatch("key transfer with none expected", '0, 72'(got));
         end else begin
            want = pending_keys.pop_front();
            if (got.value !== want.value)
               note_mismatch("key_value", 72'(want.value), 72'(got.value));
            if (got.length !== want.length)
               note_mismatch("key_length", 72'(want.length), 72'(got.length));
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------
   initial begin : stimulus
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cfg_shadow  = '{SHORT_TIME_RST, LONG_TIME_RST, TOLERANCE_RST, GAP_TIME_RST,
                      GAP_TOLERANCE_RST, KEY_BITS_RST};
      dec_phase   = PH_IDLE;
      dec_saved   = '0;
      dec_store   = '0;
      dec_count   = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every register must come out of reset at its default.
      for (int i = 0; i < 6; i++) check_register(csr_index_type'(i));

      // Directed part: short keys at the default timings.
      write_register(CSR_KEY_BITS, 2);
      foreach (directed_rows[i])
         send_segment(directed_rows[i].lvl, directed_rows[i].dur,
                      directed_rows[i].kind, directed_rows[i].key);

      // The sink holds off for a long stretch while two-bit keys keep coming,
      // so the result register fills and the decoder stops taking segments.
      // The source then waits until every key has been delivered.
      sink_hold_off = 1'b1;
      steady        = 1'b1;
      repeat (10) send_frame(2, 1'b1, 1'b1);
      steady        = 1'b0;
      wait_for_keys();

      // The default setting.
      set_config(230, 1550, 160, 12400, 2080, 18);
      run_random(120);

      // Extremes: exact-match timings at the ends of the 20-bit range and
      // the widest key.
      set_config(1, 1048575, 1, 1048575, 1, 64);
      run_random(130);

      // Short and long windows overlap, so a high can count as both.
      set_config(100, 150, 60, 5000, 1000, 3);
      run_random(100);

      // key_bits of zero: with no tolerance nothing is ever a bit, and with
      // the widest gap window any low closes the frame.
      set_config(500, 1000, 0, 20000, 1048575, 0);
      run_random(70);

      // key_bits above 64: only the last 64 bits are kept. One frame runs
      // past 255 bits, where the count must stick at its maximum and never
      // come round to key_bits again.
      set_config(40, 120, 30, 800, 100, 100);
      run_random(90);
      send_frame(260, 1'b1, 1'b1);

      // Random timings, the first with the shortest key.
      for (int i = 0; i < 3; i++) begin
         automatic int s = $urandom_range(1, 2000);
         automatic int l = s + $urandom_range(1, 3000);
         set_config(s, l, $urandom_range(1, 400), $urandom_range(5000, 1048575),
                    $urandom_range(1, 4000), (i == 0) ? 1 : $urandom_range(1, 64));
         run_random(80);
      end

      wait_for_keys();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Hard limit on the run, many times the slowest correct run.
   initial begin : run_limit
      #30_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
